// ===== hdl/assert_macros.svh =====
// Assertion helpers for the decimal text converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_DIS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_DIS(lbl, clk, rst, prop, msg)
`define ASSERT_ALL(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/bda_pkg.sv =====
package bda_pkg;

  localparam int VALUE_W   = 32;
  localparam int DIGIT_W   = 4;
  localparam int ASCII_W   = 6;
  localparam int BIT_CNT_W = 5;

  localparam logic [ASCII_W-1:0]   ASCII_ZERO = 6'h30;
  localparam logic [ASCII_W-1:0]   ASCII_NINE = 6'h39;
  localparam logic [BIT_CNT_W-1:0] LAST_BIT   = BIT_CNT_W'(VALUE_W - 1);

  typedef struct packed {
    logic load;
    logic dabble;
    logic shift_digit;
  } bda_cmd_t;

endpackage

// ===== hdl/bda_bcd_shift.sv =====
module bda_bcd_shift #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                            clk,
  input  bda_pkg::bda_cmd_t               cmd,
  input  logic [bda_pkg::VALUE_W-1:0]     value,
  output logic [bda_pkg::DIGIT_W-1:0]     top_digit
);

  localparam int BCD_W = bda_pkg::DIGIT_W * MAX_DIGITS;

  logic [bda_pkg::VALUE_W-1:0] bin;
  logic [BCD_W-1:0]            bcd;
  logic [BCD_W-1:0]            adj;

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[i*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W] >= 4'd5) begin
        adj[i*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W] =
          bcd[i*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W] + 4'd3;
      end else begin
        adj[i*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W] =
          bcd[i*bda_pkg::DIGIT_W +: bda_pkg::DIGIT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin <= value;
      bcd <= '0;
    end else if (cmd.dabble) begin
      bin <= bin << 1;
      bcd <= {adj[BCD_W-2:0], bin[bda_pkg::VALUE_W-1]};
    end else if (cmd.shift_digit) begin
      bcd <= bcd << bda_pkg::DIGIT_W;
    end
  end

  assign top_digit = bcd[BCD_W-1 -: bda_pkg::DIGIT_W];

endmodule

// ===== hdl/binary_to_decimal_ascii.sv =====
// Channel  | Dir | Handshake            | Fields
// ---------+-----+----------------------+--------------------------
// input    | in  | in_valid / in_stall  | value[31:0]
// output   | out | out_valid / out_stall| ascii_digit[5:0], last
//
// One word in is accepted, shifted through shift-add-3 steps for all 32 bits,
// stripped of suppressed leading zeros one digit at a time until the zero skip
// is left, and then sent one digit at a time, paced by the single dabble unit
// and the digit shifter.
// Reset (rst, synchronous) returns the sequencer to idle and empties the output.
// out_stall holds the digit shifter; the input is stalled until the last digit
// sits in the output register.
module binary_to_decimal_ascii #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bda_pkg::VALUE_W-1:0]   value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bda_pkg::ASCII_W-1:0]   ascii_digit,
  output logic                          last
);

`include "assert_macros.svh"

  localparam int DIGIT_SLOTS = 20;
  localparam int DIGITS = (MAX_DIGITS < 1) ? 1 :
                          ((MAX_DIGITS > DIGIT_SLOTS) ? DIGIT_SLOTS : MAX_DIGITS);
  localparam int REM_W = $clog2(DIGITS + 1);
  localparam logic [REM_W-1:0] REM_ONE  = REM_W'(1);
  localparam logic [REM_W-1:0] REM_FULL = REM_W'(DIGITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  state_t                          state;
  logic [bda_pkg::BIT_CNT_W-1:0]   bitcnt;
  logic [REM_W-1:0]                rem;
  bda_pkg::bda_cmd_t               cmd;
  logic [bda_pkg::DIGIT_W-1:0]     top_digit;
  logic                            out_load;
  logic                            skip_zero;

  assign in_stall  = (state != ST_IDLE);
  assign out_load  = (state == ST_EMIT) && (!out_valid || !out_stall);
  assign skip_zero = (top_digit == '0) && (rem != REM_ONE);

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: cmd.load = in_valid;
      ST_CONV: cmd.dabble = 1'b1;
      ST_SKIP: cmd.shift_digit = skip_zero;
      ST_EMIT: cmd.shift_digit = out_load;
      default: cmd = '0;
    endcase
  end

  bda_bcd_shift #(
    .MAX_DIGITS (DIGITS)
  ) u_shift (
    .clk       (clk),
    .cmd       (cmd),
    .value     (value),
    .top_digit (top_digit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          bitcnt <= '0;
          if (in_valid) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          bitcnt <= bitcnt + 1'b1;
          if (bitcnt == bda_pkg::LAST_BIT) begin
            rem   <= REM_FULL;
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (skip_zero) begin
            rem <= rem - 1'b1;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            out_valid   <= 1'b1;
            ascii_digit <= bda_pkg::ASCII_ZERO + bda_pkg::ASCII_W'(top_digit);
            last        <= (rem == REM_ONE);
            rem         <= rem - 1'b1;
            if (rem == REM_ONE) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_ALL(a_reset_clears, clk, rst |=> (state == ST_IDLE && !out_valid), "reset did not clear")
  `ASSERT_DIS(a_digit_range, clk, rst, out_valid |-> (ascii_digit >= bda_pkg::ASCII_ZERO && ascii_digit <= bda_pkg::ASCII_NINE), "digit code out of range")
  `ASSERT_DIS(a_more_follow, clk, rst, (out_valid && !last) |-> (state == ST_EMIT), "digit run broken")
  `ASSERT_DIS(a_last_done, clk, rst, (out_load && rem == REM_ONE) |=> (state == ST_IDLE && out_valid && last), "last digit not flagged")
  `ASSERT_DIS(a_skip_ends, clk, rst, (state == ST_SKIP && rem == REM_ONE) |=> (state == ST_EMIT), "zero skip ran past one digit")

endmodule

// ===== tb/sv/decimal_text_check.sv =====
`timescale 1ns / 100ps

module decimal_text_check #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [bda_pkg::VALUE_W-1:0] value,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [bda_pkg::ASCII_W-1:0] ascii_digit,
  input  logic                        last,
  output int                          fail_count,
  output int                          pending
);

  typedef struct packed {
    logic [bda_pkg::ASCII_W-1:0] code;
    logic                        last;
  } digit_word_t;

  digit_word_t expected_digits[$];
  digit_word_t head;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
    fail_count++;
  endtask

  function automatic void queue_digits(input logic [bda_pkg::VALUE_W-1:0] num);
    logic [3:0]  digs [20];
    logic [63:0] rest;
    int          width;
    int          count;
    digit_word_t word;
    width = MAX_DIGITS;
    if (width < 1) width = 1;
    if (width > 20) width = 20;
    rest = 64'(num);
    for (int i = 0; i < 20; i++) digs[i] = '0;
    for (int i = 0; i < width; i++) begin
      digs[i] = 4'(rest % 10);
      rest    = rest / 10;
    end
    count = 1;
    for (int i = 0; i < width; i++) begin
      if (digs[i] != 0) count = i + 1;
    end
    for (int k = count - 1; k >= 0; k--) begin
      word.code = bda_pkg::ASCII_ZERO + bda_pkg::ASCII_W'(digs[k]);
      word.last = (k == 0);
      expected_digits.push_back(word);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) queue_digits(value);
      if (out_valid && !out_stall) begin
        if (expected_digits.size() == 0) begin
          report_mismatch("unexpected word, ascii_digit", -1, int'(ascii_digit));
        end else begin
          head = expected_digits.pop_front();
          if (ascii_digit !== head.code)
            report_mismatch("ascii_digit", int'(head.code), int'(ascii_digit));
          if (last !== head.last)
            report_mismatch("last", int'(head.last), int'(last));
        end
      end
    end
    pending = expected_digits.size();
  end

endmodule

// ===== tb/sv/binary_to_decimal_ascii_test.sv =====
`timescale 1ns / 100ps

module binary_to_decimal_ascii_test;

  localparam int MAX_DIGITS  = 10;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic [bda_pkg::VALUE_W-1:0] value;
  logic                        out_valid;
  logic                        out_stall;
  logic [bda_pkg::ASCII_W-1:0] ascii_digit;
  logic                        last;
  int                          fail_count;
  int                          pending;
  int                          cycle_count;
  bit                          busy_phase;
  bit                          hold_req;

  binary_to_decimal_ascii #(
    .MAX_DIGITS (MAX_DIGITS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ascii_digit (ascii_digit),
    .last        (last)
  );

  decimal_text_check #(
    .MAX_DIGITS (MAX_DIGITS)
  ) i_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ascii_digit (ascii_digit),
    .last        (last),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 17) return $urandom_range(0, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] pow10(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  function automatic logic [31:0] random_number();
    int          n;
    int          pick;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] p;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      n  = $urandom_range(1, 10);
      lo = (n == 1) ? 64'd0 : pow10(n - 1);
      hi = pow10(n) - 1;
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      return 32'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
    end else if (pick <= 7) begin
      return $urandom;
    end else if (pick == 8) begin
      p = pow10($urandom_range(1, 9));
      return 32'((64'($urandom) % (64'h1_0000_0000 / p)) * p);
    end
    p = pow10($urandom_range(1, 9));
    return 32'(p - 1 + $urandom_range(0, 2));
  endfunction

  task automatic send_word(input logic [31:0] num);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    value    <= num;
    do @(posedge clk); while (in_stall);
    gap = busy_phase ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // receiver: random stall runs, plus one long hold on request
  initial begin
    int  run_left;
    bit  stalling;
    run_left = 0;
    stalling = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          stalling = !busy_phase && ($urandom_range(0, 2) == 0);
          run_left = stalling ? pick_gap() + 1 : $urandom_range(1, 12);
        end
        run_left--;
        out_stall <= stalling;
      end
    end
  end

  initial begin
    logic [31:0] directed_values [];
    directed_values = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101, 32'd12345,
      32'd99999, 32'd100000, 32'd999999999, 32'd1000000000, 32'd1000000001,
      32'd2147483647, 32'd2147483648, 32'hAAAA_AAAA, 32'h5555_5555,
      32'd4000000000, 32'd4294967294, 32'hFFFF_FFFF, 32'd0, 32'd7
    };
    rst        = 1'b1;
    in_valid   = 1'b0;
    value      = '0;
    out_stall  = 1'b0;
    busy_phase = 1'b0;
    hold_req   = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_values[i]) send_word(directed_values[i]);
    repeat (80) send_word(random_number());

    busy_phase = 1'b1;
    repeat (50) send_word(random_number());

    hold_req = 1'b1;
    repeat (30) send_word(random_number());
    busy_phase = 1'b0;

    repeat (50) send_word(random_number());

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
